FILE: hw/rtl/bsp_pkg.sv
// Shared widths, constants and helpers for the B-spline span and basis unit.
// No dependencies; imported by bspline_span_and_basis_unit.
`default_nettype none
package bsp_pkg;

    localparam int KNOT_DEPTH = 64;  // knot table entries
    localparam int MAX_DEGREE = 7;   // highest supported degree

    localparam int KNOT_W  = 32;  // signed Q8.24 knot / parameter
    localparam int DIFF_W  = 33;  // knot minus parameter
    localparam int DEN_W   = 34;  // sum of two differences
    localparam int BASIS_W = 25;  // unsigned Q1.24
    localparam int PROD_W  = 58;  // difference times basis, signed
    localparam int QMAG_W  = 57;  // magnitude of product / quotient
    localparam int SUM_W   = 59;  // saved plus new term
    localparam int SPAN_W  = 6;
    localparam int IDX_W   = 3;
    localparam int ADDR7_W = 7;   // wide enough for n+p+1 at full range

    // input beat kinds (tuser)
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // configuration register indexes
    localparam logic CFG_DEGREE = 1'b0;
    localparam logic CFG_LAST   = 1'b1;

    localparam logic [BASIS_W-1:0] ONE_Q24 = BASIS_W'(1) << 24;

    // Clamp a signed sum into the basis range 0 .. 1.0
    function automatic logic [BASIS_W-1:0] sat_basis(input logic signed [SUM_W-1:0] x);
        logic [BASIS_W-1:0] res;
        if (x < 0) begin
            res = '0;
        end else if (x > $signed({{(SUM_W-BASIS_W){1'b0}}, ONE_Q24})) begin
            res = ONE_Q24;
        end else begin
            res = x[BASIS_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/bspline_span_and_basis_unit.sv
// B-spline span search and Cox-de Boor basis unit on one shared multiplier and divider; bsp_pkg.
// Load beat: writes one knot, no result. Evaluate: range checks and a binary span search read knots,
// then rows j = 1..p of terms (two restoring divides a term, none for a zero-width term),
// then p+1 result beats; a refused evaluate presents a single error beat instead.
// Not ready from an evaluate beat until its last result or error beat; next beat the cycle after.
// Sync active-low reset: sequencer idle, degree and last_index 3, knot table kept.
`default_nettype none
module bspline_span_and_basis_unit
    import bsp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [5:0]  i_cfg_wdata,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,  // [5:0] knot_index, [37:6] value, zero fill
    input  wire logic        i_s_axis_tuser,  // op: 0 load knot, 1 evaluate
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [39:0]      o_m_axis_tdata,  // [5:0] span, [8:6] basis_index,
                                              // [33:9] basis_value, zero fill
    output logic             o_m_axis_tuser,  // range_error
    output logic             o_m_axis_tlast   // last
);

    localparam int AW = (KNOT_DEPTH > 1) ? $clog2(KNOT_DEPTH) : 1;
    localparam int IW = (MAX_DEGREE > 0) ? $clog2(MAX_DEGREE + 1) : 1;
    localparam int CW = IW + 1;
    localparam int QCW = $clog2(QMAG_W);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CHK0 = 5'd1;   // u below knot 0?
    localparam logic [4:0] ST_CHK1 = 5'd2;   // u above knot n+p+1?
    localparam logic [4:0] ST_CHKP = 5'd3;   // u on knot p
    localparam logic [4:0] ST_CHKN = 5'd4;   // u on knot n+1
    localparam logic [4:0] ST_SRCH = 5'd5;
    localparam logic [4:0] ST_SCMP = 5'd6;
    localparam logic [4:0] ST_BJ   = 5'd7;   // fetch knot span+1-j
    localparam logic [4:0] ST_BL   = 5'd8;   // left[j], fetch knot span+j
    localparam logic [4:0] ST_BR   = 5'd9;   // right[j]
    localparam logic [4:0] ST_DEN  = 5'd10;
    localparam logic [4:0] ST_MUL  = 5'd11;
    localparam logic [4:0] ST_DIVI = 5'd12;
    localparam logic [4:0] ST_DIV  = 5'd13;
    localparam logic [4:0] ST_DIVE = 5'd14;
    localparam logic [4:0] ST_ACC  = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;
    localparam logic [4:0] ST_ERR  = 5'd17;

    logic [4:0] r_state;

    logic [2:0] r_degree;
    logic [5:0] r_last;

    logic [KNOT_W-1:0] r_mem [KNOT_DEPTH];
    logic signed [KNOT_W-1:0] r_rdata;
    logic [AW-1:0] w_addr;

    logic signed [KNOT_W-1:0] r_u;
    logic [ADDR7_W-1:0] r_lo, r_hi;
    logic [SPAN_W-1:0]  r_span;
    logic [CW-1:0]      r_j, r_r, r_k;

    logic signed [DIFF_W-1:0] r_left  [MAX_DEGREE+1];
    logic signed [DIFF_W-1:0] r_right [MAX_DEGREE+1];
    logic [BASIS_W-1:0]       r_nb    [MAX_DEGREE+1];

    logic signed [PROD_W-1:0] r_saved, r_a, r_b, r_prod;
    logic signed [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]         r_dmag;
    logic                     r_second, r_neg;
    logic [QMAG_W-1:0]        r_q;
    logic [DEN_W:0]           r_rem;
    logic [QCW-1:0]           r_cnt;

    // Sequencer helpers
    logic                 w_in_acc, w_out_acc;
    logic [ADDR7_W-1:0]   w_p7, w_n7, w_top, w_mid;
    logic                 w_cfg_bad;
    logic [CW-1:0]        w_rp1, w_jmr;
    logic [IW-1:0]        w_ir, w_irp1, w_ijr, w_ij;
    logic signed [DEN_W-1:0]  w_den;
    logic signed [DIFF_W-1:0] w_mop;
    logic signed [PROD_W:0]   w_mul;
    logic [PROD_W-1:0]        w_pabs;
    logic [DEN_W:0]           w_sh, w_sub;
    logic signed [PROD_W-1:0] w_quot;
    logic signed [SUM_W-1:0]  w_sum;
    logic [CW-1:0]            w_pc;
    logic                     w_u_lt;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    assign w_p7  = ADDR7_W'(r_degree);
    assign w_n7  = ADDR7_W'(r_last);
    assign w_top = w_n7 + w_p7 + ADDR7_W'(1);
    assign w_mid = (r_lo + r_hi) >> 1;
    assign w_pc  = CW'(r_degree);
    assign w_cfg_bad = (32'(r_degree) > MAX_DEGREE) || (r_last < 6'(r_degree)) ||
                       (32'(w_top) >= KNOT_DEPTH);

    assign w_rp1  = r_r + CW'(1);
    assign w_jmr  = r_j - r_r;
    assign w_ir   = r_r[IW-1:0];
    assign w_irp1 = w_rp1[IW-1:0];
    assign w_ijr  = w_jmr[IW-1:0];
    assign w_ij   = r_j[IW-1:0];

    assign w_u_lt = r_u < r_rdata;

    // Knot fetch address for the next state
    always_comb begin
        unique case (r_state)
            ST_CHK0: w_addr = AW'(w_top);
            ST_CHK1: w_addr = AW'(w_p7);
            ST_CHKP: w_addr = AW'(w_n7 + ADDR7_W'(1));
            ST_SRCH: w_addr = AW'(w_mid);
            ST_BJ:   w_addr = AW'(ADDR7_W'(r_span) + ADDR7_W'(1) - ADDR7_W'(r_j));
            ST_BL:   w_addr = AW'(ADDR7_W'(r_span) + ADDR7_W'(r_j));
            default: w_addr = '0;
        endcase
    end

    // Shared arithmetic
    assign w_den  = DEN_W'(r_right[w_irp1]) + DEN_W'(r_left[w_ijr]);
    assign w_mop  = r_second ? r_left[w_ijr] : r_right[w_irp1];
    assign w_mul  = w_mop * $signed({1'b0, r_nb[w_ir]});
    assign w_pabs = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : r_prod;
    assign w_sh   = {r_rem[DEN_W-1:0], r_q[QMAG_W-1]};
    assign w_sub  = w_sh - {1'b0, r_dmag};
    assign w_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign w_sum  = SUM_W'(r_saved) + SUM_W'(r_a);

    // Knot table
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_s_axis_tuser == OP_LOAD &&
            32'(i_s_axis_tdata[5:0]) < KNOT_DEPTH) begin
            r_mem[AW'(i_s_axis_tdata[5:0])] <= i_s_axis_tdata[37:6];
        end
        r_rdata <= r_mem[w_addr];
    end

    // Configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= 3'd3;
            r_last   <= 6'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEGREE: r_degree <= i_cfg_wdata[2:0];
                CFG_LAST:   r_last   <= i_cfg_wdata;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc && i_s_axis_tuser != OP_LOAD) begin
                        r_u     <= i_s_axis_tdata[37:6];
                        r_state <= ST_CHK0;
                    end
                end
                ST_CHK0: begin
                    if (w_cfg_bad || w_u_lt) r_state <= ST_ERR;
                    else r_state <= ST_CHK1;
                end
                ST_CHK1: begin
                    if (r_u > r_rdata) r_state <= ST_ERR;
                    else r_state <= ST_CHKP;
                end
                ST_CHKP: begin
                    if (r_u == r_rdata) begin
                        r_span  <= SPAN_W'(r_degree);
                        r_nb[0] <= ONE_Q24;
                        r_j     <= CW'(1);
                        r_state <= ST_BJ;
                    end else begin
                        r_state <= ST_CHKN;
                    end
                end
                ST_CHKN: begin
                    if (r_u == r_rdata) begin
                        r_span  <= r_last;
                        r_nb[0] <= ONE_Q24;
                        r_j     <= CW'(1);
                        r_state <= ST_BJ;
                    end else begin
                        r_lo    <= w_p7;
                        r_hi    <= w_n7 + ADDR7_W'(1);
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (r_hi - r_lo > ADDR7_W'(1)) begin
                        r_state <= ST_SCMP;
                    end else begin
                        r_span  <= SPAN_W'(r_lo);
                        r_nb[0] <= ONE_Q24;
                        r_j     <= CW'(1);
                        r_state <= ST_BJ;
                    end
                end
                ST_SCMP: begin
                    if (w_u_lt) r_hi <= w_mid;
                    else r_lo <= w_mid;
                    r_state <= ST_SRCH;
                end
                ST_BJ: r_state <= ST_BL;
                ST_BL: begin
                    r_left[w_ij] <= DIFF_W'(r_u) - DIFF_W'(r_rdata);
                    r_state      <= ST_BR;
                end
                ST_BR: begin
                    r_right[w_ij] <= DIFF_W'(r_rdata) - DIFF_W'(r_u);
                    r_r           <= '0;
                    r_saved       <= '0;
                    r_state       <= ST_DEN;
                end
                ST_DEN: begin
                    r_second <= 1'b0;
                    if (w_den == 0) begin
                        // degenerate span: both terms vanish
                        r_a     <= '0;
                        r_b     <= '0;
                        r_state <= ST_ACC;
                    end else begin
                        r_den   <= w_den;
                        r_dmag  <= w_den[DEN_W-1] ? DEN_W'(-w_den) : w_den;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= PROD_W'(w_mul);
                    r_state <= ST_DIVI;
                end
                ST_DIVI: begin
                    r_q     <= w_pabs[QMAG_W-1:0];
                    r_neg   <= r_prod[PROD_W-1] ^ r_den[DEN_W-1];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (!w_sub[DEN_W]) begin
                        r_rem <= w_sub;
                        r_q   <= {r_q[QMAG_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_sh;
                        r_q   <= {r_q[QMAG_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + QCW'(1);
                    if (r_cnt == QCW'(QMAG_W - 1)) r_state <= ST_DIVE;
                end
                ST_DIVE: begin
                    if (!r_second) begin
                        r_a      <= w_quot;
                        r_second <= 1'b1;
                        r_state  <= ST_MUL;
                    end else begin
                        r_b     <= w_quot;
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_nb[w_ir] <= sat_basis(w_sum);
                    r_saved    <= r_b;
                    if (w_rp1 == r_j) begin
                        r_nb[w_ij] <= sat_basis(SUM_W'(r_b));
                        r_j        <= r_j + CW'(1);
                        if (r_j == w_pc) begin
                            r_k     <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_BJ;
                        end
                    end else begin
                        r_r     <= w_rp1;
                        r_state <= ST_DEN;
                    end
                end
                ST_OUT: begin
                    if (w_out_acc) begin
                        if (r_k == w_pc) r_state <= ST_IDLE;
                        r_k <= r_k + CW'(1);
                    end
                end
                ST_ERR: begin
                    if (w_out_acc) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Ports
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT) || (r_state == ST_ERR);
    assign o_m_axis_tuser  = (r_state == ST_ERR);
    assign o_m_axis_tlast  = (r_state == ST_ERR) || (r_k == w_pc);
    assign o_m_axis_tdata  = (r_state == ST_OUT) ?
        {6'b0, r_nb[r_k[IW-1:0]], IDX_W'(r_k), r_span} : '0;

endmodule
`default_nettype wire
